### hw/rtl/plist_pkg.sv
`default_nettype none

package plist_pkg;

	// fixed field widths of the item and result
	localparam int MODE_W   = 3;
	localparam int POS_W    = 8;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 7;

	// parameter defaults
	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_ITEM_WIDTH = 32;

	// fan-in of one node of the removed-item reduction tree
	localparam int TREE_FANIN = 8;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INS_POS  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REM_HEAD = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REM_TAIL = 3'd4;
	localparam logic [MODE_W-1:0] MODE_REM_POS  = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_REM = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_INS = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [POS_W-1:0]  position;
		logic [VALUE_W-1:0]       item_value;
	} cmd_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  removed_item;
		logic                removed_valid;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  item_count;
	} res_t;

	// shift command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/plist_cell.sv
`default_nettype none

module plist_cell #(
	parameter int W     = plist_pkg::DEF_ITEM_WIDTH,
	parameter int IDX_W = 6,
	parameter int INDEX = 0
) (
	input  wire logic                  clk,
	input  wire plist_pkg::cell_cmd_t  cmd,
	input  wire logic [IDX_W-1:0]      pos,
	input  wire logic [W-1:0]          new_item,
	input  wire logic [W-1:0]          left,
	input  wire logic [W-1:0]          right,
	output logic [W-1:0]               data,
	output logic [W-1:0]               tap
);

	logic [W-1:0] data_q;
	logic         at_pos;
	logic         past_pos;

	assign at_pos   = (pos == IDX_W'(INDEX));
	assign past_pos = (pos < IDX_W'(INDEX));

	// insert: cells above the slot take the left neighbor, the slot takes the new item
	// remove: the slot and everything above take the right neighbor
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (at_pos) begin
				data_q <= new_item;
			end else if (past_pos) begin
				data_q <= left;
			end
		end else if (cmd.rem) begin
			if (at_pos || past_pos) begin
				data_q <= right;
			end
		end
	end

	assign data = data_q;
	assign tap  = (cmd.rem && at_pos) ? data_q : '0;

endmodule

`default_nettype wire

### hw/rtl/plist_or_tree.sv
`default_nettype none

module plist_or_tree #(
	parameter int N = plist_pkg::DEF_CAPACITY,
	parameter int W = plist_pkg::DEF_ITEM_WIDTH
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] leaves [N],
	output logic [W-1:0]      root
);

	localparam int FAN     = plist_pkg::TREE_FANIN;
	localparam int FAN_LOG = $clog2(FAN);
	localparam int LEVELS  = ($clog2(N) + FAN_LOG - 1) / FAN_LOG;

	// tree_q[l] holds level l+1; unused nodes stay zero
	logic [W-1:0] tree_q [LEVELS][N];

	for (genvar l = 0; l < LEVELS; l++) begin : g_level
		for (genvar n = 0; n < N; n++) begin : g_node
			if (n * FAN < N) begin : g_live
				logic [W-1:0] acc;

				always_comb begin
					acc = '0;
					for (int k = 0; k < FAN; k++) begin
						if (n * FAN + k < N) begin
							if (l == 0) begin
								acc = acc | leaves[n * FAN + k];
							end else begin
								acc = acc | tree_q[(l > 0) ? l - 1 : 0][n * FAN + k];
							end
						end
					end
				end

				// first level samples the cells only on the accepting edge
				always_ff @(posedge clk) begin
					if (l != 0 || en) begin
						tree_q[l][n] <= acc;
					end
				end
			end else begin : g_dead
				always_ff @(posedge clk) begin
					tree_q[l][n] <= '0;
				end
			end
		end
	end

	assign root = tree_q[LEVELS-1][0];

endmodule

`default_nettype wire

### hw/rtl/positional_list_engine.sv
`default_nettype none

// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------------------------------------------
// cmd     | in        | cmd_valid, cmd_ready | mode, position, item_value
// res     | out       | res_valid, res_ready | removed_item, removed_valid, status, item_count
//
// one result per command, with the removed item picked by the registered 8-ary tree
// that ORs the cell taps; the result is sent once the tree's last level is loaded
// the list itself shifts in the accepting cycle, all cells at once
// reset clears the count and the handshake state; entry contents are not cleared
// a stalled result stays in the output register; the next command is taken
// meanwhile, and a second result waits until the first transfer completes

module positional_list_engine #(
	parameter int CAPACITY   = plist_pkg::DEF_CAPACITY,
	parameter int ITEM_WIDTH = plist_pkg::DEF_ITEM_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	input  wire plist_pkg::cmd_t  cmd,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output plist_pkg::res_t       res
);

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int CMP_W   = (CNT_W > plist_pkg::POS_W) ? CNT_W : plist_pkg::POS_W;
	localparam int FAN_LOG = $clog2(plist_pkg::TREE_FANIN);
	localparam int LEVELS  = ($clog2(CAPACITY) + FAN_LOG - 1) / FAN_LOG;
	localparam int WAIT_W  = $clog2(LEVELS + 1);
	localparam int VALUE_W = plist_pkg::VALUE_W;
	localparam int COUNT_W = plist_pkg::COUNT_W;

	// list occupancy
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;

	// result in flight through the tree
	logic                          busy_q;
	logic [WAIT_W-1:0]             wait_q;
	logic                          pend_valid_q;
	logic [plist_pkg::STATUS_W-1:0] pend_status_q;
	logic [CNT_W-1:0]              pend_count_q;

	// output register
	logic            res_valid_q;
	plist_pkg::res_t res_q;

	logic accept;
	logic deliver;

	// decode
	logic                           full;
	logic                           empty;
	logic                           pos_neg;
	logic [CMP_W-1:0]               pos_ext;
	logic [CMP_W-1:0]               cnt_ext;
	logic                           ins_pos_ok;
	logic                           rem_pos_ok;
	logic                           do_ins;
	logic                           do_rem;
	logic [IDX_W-1:0]               tgt;
	logic [plist_pkg::STATUS_W-1:0] status;

	// cell chain
	plist_pkg::cell_cmd_t  cell_cmd;
	logic [ITEM_WIDTH-1:0] new_item;
	logic [ITEM_WIDTH-1:0] cell_data [CAPACITY];
	logic [ITEM_WIDTH-1:0] cell_tap  [CAPACITY];
	logic [ITEM_WIDTH-1:0] picked;

	// width adapters between fixed ports and the parameterized store
	logic [ITEM_WIDTH+VALUE_W-1:0] item_in_ext;
	logic [ITEM_WIDTH+VALUE_W-1:0] item_out_ext;
	logic [CNT_W+COUNT_W-1:0]      count_out_ext;

	// result leaves the tree when its last level is loaded and the output is free
	assign deliver   = busy_q && (wait_q == '0) && (!res_valid_q || res_ready);
	assign cmd_ready = !busy_q || deliver;
	assign accept    = cmd_valid && cmd_ready;

	assign full    = (count_q == CNT_W'(CAPACITY));
	assign empty   = (count_q == '0);
	assign pos_neg = cmd.position[plist_pkg::POS_W-1];
	assign pos_ext = CMP_W'(cmd.position[plist_pkg::POS_W-2:0]);
	assign cnt_ext = CMP_W'(count_q);

	assign ins_pos_ok = !pos_neg && (pos_ext <= cnt_ext);
	assign rem_pos_ok = !pos_neg && (pos_ext < cnt_ext);

	// pick the slot and the status; full wins over a bad insert position,
	// empty wins over a bad remove position
	always_comb begin
		do_ins = 1'b0;
		do_rem = 1'b0;
		tgt    = '0;
		status = plist_pkg::ST_OK;
		unique case (cmd.mode)
			plist_pkg::MODE_INS_HEAD, plist_pkg::MODE_INS_TAIL, plist_pkg::MODE_INS_POS: begin
				if (full) begin
					status = plist_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
					priority if (cmd.mode == plist_pkg::MODE_INS_HEAD) begin
						tgt = '0;
					end else if (cmd.mode == plist_pkg::MODE_INS_TAIL) begin
						tgt = count_q[IDX_W-1:0];
					end else if (ins_pos_ok) begin
						tgt = pos_ext[IDX_W-1:0];
					end else begin
						// bad position falls back to an append
						tgt    = count_q[IDX_W-1:0];
						status = plist_pkg::ST_BAD_INS;
					end
				end
			end
			plist_pkg::MODE_REM_HEAD, plist_pkg::MODE_REM_TAIL, plist_pkg::MODE_REM_POS: begin
				if (empty) begin
					status = plist_pkg::ST_EMPTY;
				end else begin
					priority if (cmd.mode == plist_pkg::MODE_REM_HEAD) begin
						do_rem = 1'b1;
						tgt    = '0;
					end else if (cmd.mode == plist_pkg::MODE_REM_TAIL) begin
						do_rem = 1'b1;
						tgt    = IDX_W'(count_q - CNT_W'(1));
					end else if (rem_pos_ok) begin
						do_rem = 1'b1;
						tgt    = pos_ext[IDX_W-1:0];
					end else begin
						status = plist_pkg::ST_BAD_REM;
					end
				end
			end
			default: begin
				// unused codes leave the list alone
			end
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (do_ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	// the chain only moves on the accepting edge
	assign cell_cmd.ins = accept && do_ins;
	assign cell_cmd.rem = accept && do_rem;

	assign item_in_ext = {{ITEM_WIDTH{1'b0}}, cmd.item_value};
	assign new_item    = item_in_ext[ITEM_WIDTH-1:0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ITEM_WIDTH-1:0] left;
		logic [ITEM_WIDTH-1:0] right;

		// head has no left neighbor, the last cell refills from itself
		assign left  = (i == 0) ? new_item : cell_data[(i > 0) ? i - 1 : 0];
		assign right = (i == CAPACITY - 1) ? cell_data[i]
			: cell_data[(i < CAPACITY - 1) ? i + 1 : i];

		plist_cell #(
			.W     (ITEM_WIDTH),
			.IDX_W (IDX_W),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.cmd      (cell_cmd),
			.pos      (tgt),
			.new_item (new_item),
			.left     (left),
			.right    (right),
			.data     (cell_data[i]),
			.tap      (cell_tap[i])
		);
	end

	// removed item: only the removing cell drives its tap, the tree ORs them together
	plist_or_tree #(
		.N (CAPACITY),
		.W (ITEM_WIDTH)
	) u_tree (
		.clk    (clk),
		.en     (accept),
		.leaves (cell_tap),
		.root   (picked)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			wait_q  <= '0;
		end else begin
			if (accept) begin
				count_q <= count_next;
				busy_q  <= 1'b1;
				wait_q  <= WAIT_W'(LEVELS - 1);
			end else begin
				if (deliver) begin
					busy_q <= 1'b0;
				end
				if (busy_q && wait_q != '0) begin
					wait_q <= wait_q - WAIT_W'(1);
				end
			end
		end
	end

	// side fields of the result ride along with the tree
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_valid_q  <= do_rem;
			pend_status_q <= status;
			pend_count_q  <= count_next;
		end
	end

	assign item_out_ext  = {{VALUE_W{1'b0}}, picked};
	assign count_out_ext = {{COUNT_W{1'b0}}, pend_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (deliver) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			res_q.removed_item  <= item_out_ext[VALUE_W-1:0];
			res_q.removed_valid <= pend_valid_q;
			res_q.status        <= pend_status_q;
			res_q.item_count    <= count_out_ext[COUNT_W-1:0];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// occupancy never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list count above capacity");

	// a new result only appears for a command that was in flight
	a_res_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(busy_q))
		else $error("result without a command in flight");

	// a real removed item always comes with an ok status
	a_removed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.removed_valid) |-> (res_q.status == plist_pkg::ST_OK))
		else $error("removed item with error status");

	// a transfer in starts the tree walk
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && wait_q == WAIT_W'(LEVELS - 1)))
		else $error("accepted command not tracked");
`endif

endmodule

`default_nettype wire

### bench/positional_list_engine_tb.sv
`default_nettype none

// self-checking bench for the positional list engine
// a mirror of the list predicts one result per accepted command; a receiver process
// compares each result transfer field by field against the oldest prediction
// tests run in turn: directed corner cases, fill to capacity and drain, output
// hold-off, pauses until the pipe is empty, a stretch with no idling, random phases

module positional_list_engine_tb;

	localparam int CAPACITY     = plist_pkg::DEF_CAPACITY;
	localparam int ITEM_WIDTH   = plist_pkg::DEF_ITEM_WIDTH;
	localparam int MODE_W       = plist_pkg::MODE_W;
	localparam int POS_W        = plist_pkg::POS_W;
	localparam int VALUE_W      = plist_pkg::VALUE_W;
	localparam int COUNT_W      = plist_pkg::COUNT_W;
	localparam int LATENCY      = 2;       // tree depth at 64 entries
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 150;     // receiver hold-off for the backpressure test
	localparam int RANDOM_ITEMS = 1150;
	localparam int IDLE_PCT     = 11;

	// modes with no operation, not named in the package
	localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	plist_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	plist_pkg::res_t res;

	// mirror of the list contents and fill level, updated at each accepted command
	logic [ITEM_WIDTH-1:0] list_mirror [CAPACITY];
	int list_len = 0;

	plist_pkg::res_t pending_list_results [$];   // predicted results in command order
	int mismatches = 0;
	int cycle_count = 0;
	bit calm = 1'b0;                  // no idling on either side while set
	bit hold_req = 1'b0;              // asks the receiver for a long hold-off
	int hold_left = 0;

	positional_list_engine #(
		.CAPACITY(CAPACITY),
		.ITEM_WIDTH(ITEM_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// apply one command to the mirror and work out the result it must produce
	task automatic apply_list_op(input plist_pkg::cmd_t c, output plist_pkg::res_t r);
		int p;
		int at;
		logic [ITEM_WIDTH-1:0] taken;
		p = int'(c.position);
		at = 0;
		taken = '0;
		r = '0;
		case (c.mode)
			plist_pkg::MODE_INS_HEAD, plist_pkg::MODE_INS_TAIL, plist_pkg::MODE_INS_POS: begin
				// a full list drops the item, even with a bad position
				if (list_len >= CAPACITY) begin
					r.status = plist_pkg::ST_FULL;
				end else begin
					if (c.mode == plist_pkg::MODE_INS_HEAD) begin
						at = 0;
					end else if (c.mode == plist_pkg::MODE_INS_TAIL) begin
						at = list_len;
					end else if (p < 0 || p > list_len) begin
						// bad position: appended at the tail
						at = list_len;
						r.status = plist_pkg::ST_BAD_INS;
					end else begin
						at = p;
					end
					for (int i = list_len; i > at; i--)
						list_mirror[i] = list_mirror[i-1];
					list_mirror[at] = c.item_value[ITEM_WIDTH-1:0];
					list_len++;
				end
			end
			plist_pkg::MODE_REM_HEAD, plist_pkg::MODE_REM_TAIL, plist_pkg::MODE_REM_POS: begin
				// empty wins over a bad position
				if (list_len == 0) begin
					r.status = plist_pkg::ST_EMPTY;
				end else if (c.mode == plist_pkg::MODE_REM_POS && (p < 0 || p >= list_len)) begin
					r.status = plist_pkg::ST_BAD_REM;
				end else begin
					if (c.mode == plist_pkg::MODE_REM_HEAD)
						at = 0;
					else if (c.mode == plist_pkg::MODE_REM_TAIL)
						at = list_len - 1;
					else
						at = p;
					taken = list_mirror[at];
					for (int i = at; i + 1 < list_len; i++)
						list_mirror[i] = list_mirror[i+1];
					list_len--;
					r.removed_item = VALUE_W'(taken);
					r.removed_valid = 1'b1;
				end
			end
			default: begin
				// spare modes leave the list alone
			end
		endcase
		r.item_count = COUNT_W'(list_len);
	endtask

	// one command transfer; the prediction is made at the accepting edge
	task automatic send_cmd(input plist_pkg::cmd_t c);
		plist_pkg::res_t r;
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		apply_list_op(c, r);
		pending_list_results.push_back(r);
	endtask

	// sender pauses until every predicted result has been transferred
	task automatic wait_results();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_list_results.size() != 0);
	endtask

	function automatic plist_pkg::cmd_t make_op(input logic [MODE_W-1:0] mode, input int pos,
			input logic [VALUE_W-1:0] value);
		plist_pkg::cmd_t c;
		c.mode = mode;
		c.position = POS_W'(pos);
		c.item_value = value;
		return c;
	endfunction

	// random command that tends to grow or shrink the list, with some noise
	function automatic plist_pkg::cmd_t make_cmd(input bit grow);
		plist_pkg::cmd_t c;
		int pick;
		case ($urandom_range(9))
			0: c.item_value = '0;
			1: c.item_value = '1;
			default: c.item_value = $urandom;
		endcase
		c.position = POS_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 8) begin
			// noise: any mode, any position
			c.mode = MODE_W'($urandom_range(7));
		end else if (grow) begin
			case ($urandom_range(2))
				0: c.mode = plist_pkg::MODE_INS_HEAD;
				1: c.mode = plist_pkg::MODE_INS_TAIL;
				default: begin
					c.mode = plist_pkg::MODE_INS_POS;
					c.position = POS_W'($urandom_range(list_len, 0));
				end
			endcase
		end else begin
			case ($urandom_range(2))
				0: c.mode = plist_pkg::MODE_REM_HEAD;
				1: c.mode = plist_pkg::MODE_REM_TAIL;
				default: begin
					c.mode = plist_pkg::MODE_REM_POS;
					c.position = (list_len == 0) ? '0 : POS_W'($urandom_range(list_len - 1, 0));
				end
			endcase
		end
		return c;
	endfunction

	task automatic check_result(input plist_pkg::res_t got);
		plist_pkg::res_t want;
		if (pending_list_results.size() == 0) begin
			report_mismatch($sformatf("result with nothing pending: %h", got));
			return;
		end
		want = pending_list_results.pop_front();
		if (got.removed_item !== want.removed_item)
			report_mismatch($sformatf("removed_item %h expected %h",
				got.removed_item, want.removed_item));
		if (got.removed_valid !== want.removed_valid)
			report_mismatch($sformatf("removed_valid %b expected %b",
				got.removed_valid, want.removed_valid));
		if (got.status !== want.status)
			report_mismatch($sformatf("status %0d expected %0d", got.status, want.status));
		if (got.item_count !== want.item_count)
			report_mismatch($sformatf("item_count %0d expected %0d",
				got.item_count, want.item_count));
	endtask

	// receiver: checks each result transfer and drives ready, with random
	// idling, the no-idle stretch and the long hold-off counted here
	always @(posedge clk) begin
		if (res_valid && res_ready)
			check_result(res);
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// corners on a short list: empty removes, bad positions both ways, spare modes
	task automatic test_directed();
		send_cmd(make_op(plist_pkg::MODE_REM_HEAD, 0, '1));
		send_cmd(make_op(plist_pkg::MODE_REM_TAIL, 0, '0));
		send_cmd(make_op(plist_pkg::MODE_REM_POS, 0, 32'h1));
		send_cmd(make_op(plist_pkg::MODE_REM_POS, -128, 32'h2));     // empty wins over bad position
		send_cmd(make_op(plist_pkg::MODE_INS_POS, 0, '0));
		send_cmd(make_op(plist_pkg::MODE_INS_HEAD, 0, '1));
		send_cmd(make_op(plist_pkg::MODE_INS_TAIL, 127, 32'h1234_5678));
		send_cmd(make_op(plist_pkg::MODE_INS_POS, 3, 32'ha5a5_a5a5)); // position equal to count
		send_cmd(make_op(plist_pkg::MODE_INS_POS, 127, 32'h8000_0001));
		send_cmd(make_op(plist_pkg::MODE_INS_POS, -1, 32'h7fff_fffe));
		send_cmd(make_op(plist_pkg::MODE_INS_POS, -128, 32'h0000_ffff));
		send_cmd(make_op(plist_pkg::MODE_INS_POS, 2, 32'h5a5a_5a5a));
		send_cmd(make_op(MODE_SPARE_A, -1, '1));
		send_cmd(make_op(MODE_SPARE_B, 127, 32'hdead_beef));
		send_cmd(make_op(plist_pkg::MODE_REM_POS, 8, '1));           // position equal to count
		send_cmd(make_op(plist_pkg::MODE_REM_POS, -1, '0));
		send_cmd(make_op(plist_pkg::MODE_REM_POS, 127, '0));
		send_cmd(make_op(plist_pkg::MODE_REM_POS, 3, '0));
		send_cmd(make_op(plist_pkg::MODE_REM_HEAD, -128, '0));
		send_cmd(make_op(plist_pkg::MODE_REM_TAIL, 127, '0));
		send_cmd(make_op(plist_pkg::MODE_REM_POS, 0, '0));
		send_cmd(make_op(plist_pkg::MODE_REM_POS, 2, '0));
		repeat (3) send_cmd(make_op(plist_pkg::MODE_REM_TAIL, 0, '0));
	endtask

	// fill to capacity, insert into the full list, drain, remove from empty
	task automatic test_fill_drain();
		while (list_len < CAPACITY)
			send_cmd(make_cmd(1'b1));
		send_cmd(make_op(plist_pkg::MODE_INS_HEAD, 0, '1));
		send_cmd(make_op(plist_pkg::MODE_INS_TAIL, 0, '0));
		send_cmd(make_op(plist_pkg::MODE_INS_POS, -5, 32'h1));       // full wins over bad position
		send_cmd(make_op(plist_pkg::MODE_INS_POS, 127, 32'h2));
		send_cmd(make_op(plist_pkg::MODE_INS_POS, 10, 32'h3));
		send_cmd(make_op(plist_pkg::MODE_REM_POS, CAPACITY - 1, '0));
		send_cmd(make_op(plist_pkg::MODE_INS_POS, CAPACITY - 1, '1)); // back to full
		send_cmd(make_op(plist_pkg::MODE_REM_POS, CAPACITY, '0));
		while (list_len > 0)
			send_cmd(make_cmd(1'b0));
		send_cmd(make_op(plist_pkg::MODE_REM_POS, -1, '0));
		send_cmd(make_op(plist_pkg::MODE_REM_POS, 127, '0));
		send_cmd(make_op(plist_pkg::MODE_REM_HEAD, 0, '0));
	endtask

	// receiver holds off while commands keep coming, so the input stalls
	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (40)
			send_cmd(make_cmd($urandom_range(99) < 60));
		wait_results();
	endtask

	// sender pauses until the pipe is empty between bursts
	task automatic test_quiesce();
		repeat (3) begin
			repeat (15)
				send_cmd(make_cmd($urandom_range(99) < 50));
			wait_results();
		end
	endtask

	// long stretch with no idling on either side
	task automatic test_calm();
		calm = 1'b1;
		repeat (200)
			send_cmd(make_cmd(list_len < CAPACITY / 2 ? ($urandom_range(99) < 70)
				: ($urandom_range(99) < 30)));
		calm = 1'b0;
	endtask

	// random phases, each steering the fill level toward a target
	task automatic test_random();
		int target;
		int budget;
		int n;
		bit grow;
		n = 0;
		while (n < RANDOM_ITEMS) begin
			case ($urandom_range(3))
				0: target = 0;
				1: target = CAPACITY;
				default: target = $urandom_range(CAPACITY);
			endcase
			budget = $urandom_range(20, 160);
			while (budget > 0 && n < RANDOM_ITEMS) begin
				if (list_len < target)
					grow = $urandom_range(99) < 80;
				else if (list_len > target)
					grow = $urandom_range(99) < 20;
				else
					grow = 1'($urandom_range(1));
				send_cmd(make_cmd(grow));
				n++;
				budget--;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_drain();
		test_backpressure();
		test_quiesce();
		test_calm();
		test_random();
		wait_results();
		// let any stray transfer show up before the verdict
		repeat (LATENCY * 4) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
